// ===== hdl/crc8fr_pkg.sv =====
// Shared constants, types and the CRC-8 byte update for the CRC-8 frame receiver.
`default_nettype none

package crc8fr_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int CNT_W        = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = 16;

    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_TOP    = 8'h80;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    // byte positions within a frame
    localparam cnt_t POS_HDR_FIRST  = cnt_t'(0);
    localparam cnt_t POS_HDR_SECOND = cnt_t'(1);
    localparam cnt_t POS_LEN_LO     = cnt_t'(2);
    localparam cnt_t POS_LEN_HI     = cnt_t'(3);
    localparam cnt_t POS_CMD        = cnt_t'(4);
    localparam cnt_t POS_TYPE       = cnt_t'(5);
    localparam cnt_t POS_PAYLOAD    = cnt_t'(6);
    localparam cnt_t POS_LAST       = cnt_t'(BUFFER_BYTES - 1);

    localparam int PAYLOAD_HELD = 4;

    typedef struct packed {
        logic                          frame_status;
        logic [PAYLOAD_HELD-1:0][7:0]  payload;
        logic [7:0]                    body_length;
        logic [7:0]                    test_type;
        logic [7:0]                    command;
    } result_t;

    // MSB-first CRC-8, no reflection, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_TOP) != 8'h00)
                v = (v << 1) ^ CRC_POLY;
            else
                v = v << 1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crc8fr_in_stage.sv =====
// Input register stage of the CRC-8 frame receiver.
`default_nettype none

module crc8fr_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // rx_byte[7:0]
    input  wire logic       advance,
    output logic            in_valid,
    output logic [7:0]      in_byte
);
    import crc8fr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign s_axis_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
            if (s_axis_tvalid)
                byte_next = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

// ===== hdl/crc8fr_parser.sv =====
// Frame parser: header hunt, length capture, CRC-8 over the body and result build.
`default_nettype none

module crc8fr_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 out_free,
    output logic                      advance,
    output logic                      res_load,
    output crc8fr_pkg::result_t       res
);
    import crc8fr_pkg::*;

    cnt_t                         count_reg, count_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic [7:0]                   crc_reg, crc_next;
    logic [7:0]                   cmd_reg, cmd_next;
    logic [7:0]                   type_reg, type_next;
    logic [PAYLOAD_HELD-1:0][7:0] pay_reg, pay_next;

    cnt_t body_idx;
    logic in_body;
    logic produce;

    assign advance  = in_valid && out_free;
    assign body_idx = count_reg - POS_CMD;
    assign in_body  = LEN_W'(body_idx) < len_reg;

    always_comb
    begin
        count_next = count_reg + cnt_t'(1);
        len_next   = len_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        type_next  = type_reg;
        pay_next   = pay_reg;
        produce    = 1'b0;

        if (count_reg == POS_HDR_FIRST)
        begin
            if (in_byte != HDR_FIRST)
                count_next = '0;
            else
            begin
                len_next  = '0;
                crc_next  = CRC_INIT;
                cmd_next  = '0;
                type_next = '0;
                pay_next  = '0;
            end
        end
        else if (count_reg == POS_HDR_SECOND)
        begin
            // wrong second byte: back to hunting, byte is not retried as a first byte
            if (in_byte != HDR_SECOND)
                count_next = '0;
        end
        else if (count_reg == POS_LEN_LO)
            len_next[7:0] = in_byte;
        else if (count_reg == POS_LEN_HI)
            len_next[15:8] = in_byte;
        else
        begin
            // type byte is captured even when it turns out to be the CRC byte
            if (count_reg == POS_TYPE)
                type_next = in_byte;
            if (in_body)
            begin
                crc_next = crc8_update(crc_reg, in_byte);
                if (count_reg == POS_CMD)
                    cmd_next = in_byte;
                for (int j = 0; j < PAYLOAD_HELD; j++)
                begin
                    if (count_reg == POS_PAYLOAD + cnt_t'(j))
                        pay_next[j] = in_byte;
                end
            end
            else
            begin
                // CRC byte: frame done
                produce    = (len_reg != '0);
                count_next = '0;
            end
        end

        if (count_reg == POS_LAST)
            count_next = '0;
    end

    always_comb
    begin
        res.frame_status = (in_byte == crc_reg);
        res.command      = cmd_reg;
        res.test_type    = (count_reg == POS_TYPE) ? in_byte : type_reg;
        res.body_length  = len_reg[7:0];
        res.payload      = pay_reg;
    end

    assign res_load = advance && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= '0;
            crc_reg   <= CRC_INIT;
            cmd_reg   <= '0;
            type_reg  <= '0;
            pay_reg   <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            type_reg  <= type_next;
            pay_reg   <= pay_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/crc8fr_out_reg.sv =====
// Result register of the CRC-8 frame receiver, drives the master stream.
`default_nettype none

module crc8fr_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_load,
    input  wire crc8fr_pkg::result_t  res,
    output logic                      out_free,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [55:0]               m_axis_tdata,  // command, test_type, body_length,
                                                     // payload_first..payload_fourth
    output logic                      m_axis_tuser   // frame_status
);
    import crc8fr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
            valid_next = 1'b1;
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res_reg.payload, res_reg.body_length,
                            res_reg.test_type, res_reg.command};
    assign m_axis_tuser  = res_reg.frame_status;

endmodule

`default_nettype wire

// ===== hdl/crc8_frame_receiver.sv =====
// Top level of the CRC-8 frame receiver.
`default_nettype none

// Takes one received byte per cycle on the slave stream, hunts for the header
// 0xAA 0x55, reads a little-endian 16-bit body length and checks the CRC-8
// (poly 0x31, init 0, MSB first) over the body against the byte after it. Each
// completed frame with a nonzero length gives one transaction on the master
// stream, registered as the parser takes the CRC byte: tuser is 1 for a good
// frame, 0 for a CRC mismatch. Throughput is one byte per cycle, set by the
// unregistered CRC update in the parser; input stalls only while a result waits
// in the output register and the sink does not take it. Frames that reach the
// buffer size of 256 bytes before completing are dropped without a result.
module crc8_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // command, test_type, body_length,
                                             // payload_first..payload_fourth
    output logic             m_axis_tuser    // frame_status
);
    import crc8fr_pkg::*;

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       res_load;
    result_t    res;

    crc8fr_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .in_valid      (in_valid),
        .in_byte       (in_byte)
    );

    crc8fr_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .out_free (out_free),
        .advance  (advance),
        .res_load (res_load),
        .res      (res)
    );

    crc8fr_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_load      (res_load),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/crc8fr_checker.sv =====
// Port-level checker for the CRC-8 frame receiver, bound to the top level.
`default_nettype none

module crc8fr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // with no result pending the input never stalls
    a_no_stall: assert property (@(posedge clk)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // empty bodies give no result
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:16] != 8'd0)
        else $error("result with zero body length");

    // payload_fourth exists only for bodies of six bytes or more
    a_short_body: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[23:16] < 8'd6) |-> m_axis_tdata[55:48] == 8'd0)
        else $error("payload byte beyond body not zero");

endmodule

bind crc8_frame_receiver crc8fr_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
